// ===== hdl/pipc_pkg.sv =====
// shared types and constants for the pi position controller
// no dependencies
`timescale 1ns / 1ps

package pipc_pkg;

   localparam int PosW   = 8;
   localparam int GainW  = 8;
   localparam int DriveW = 16;
   localparam int CsrIdxW = 4;
   localparam int OpW    = 17;
   localparam int ProdW  = 26;

   localparam logic [CsrIdxW-1:0] RegPropGain  = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] RegIntegGain = CsrIdxW'(1);
   localparam logic [CsrIdxW-1:0] RegFfGain    = CsrIdxW'(2);
   localparam logic [CsrIdxW-1:0] RegIntegWin  = CsrIdxW'(3);

   localparam logic signed [PosW-1:0]   IntegMax = PosW'(127);
   localparam logic signed [PosW-1:0]   IntegMin = -PosW'(128);
   localparam logic signed [ProdW-1:0]  DriveMax = ProdW'(32000);
   localparam logic signed [ProdW-1:0]  DriveMin = -ProdW'(32000);

   typedef struct packed {
      logic [GainW-1:0] prop_gain;
      logic [GainW-1:0] integ_gain;
      logic [GainW-1:0] feedforward_gain;
      logic [GainW-1:0] integ_window;
   } gains_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INTEG,
      ST_MUL_P1,
      ST_MUL_P2,
      ST_MUL_I1,
      ST_MUL_I2,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MOP_ERR_FF,
      MOP_PROD_KP,
      MOP_INT_FF,
      MOP_PROD_KI
   } mul_op_type;

   typedef struct packed {
      logic       req_ready;
      logic       capture;
      logic       integ_upd;
      mul_op_type mul_op;
      logic       save_pterm;
      logic       save_sum;
      logic       load_out;
   } ctrl_type;

endpackage

// ===== hdl/pipc_if.sv =====
// handshake channels for the pi position controller
// depends on pipc_pkg
`timescale 1ns / 1ps

interface pipc_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [pipc_pkg::PosW-1:0] actual_pos;
   logic signed [pipc_pkg::PosW-1:0] target_pos;

   modport source (output valid, output actual_pos, output target_pos, input ready);
   modport sink (input valid, input actual_pos, input target_pos, output ready);
endinterface

interface pipc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [pipc_pkg::DriveW-1:0] drive_power;
   logic                               braking;

   modport source (output valid, output drive_power, output braking, input ready);
   modport sink (input valid, input drive_power, input braking, output ready);
endinterface

interface pipc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pipc_pkg::CsrIdxW-1:0]        index;
   logic [pipc_pkg::GainW-1:0]          data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pi_position_controller.sv =====
// pi position controller: each tick steps through the integrator update, the four passes
// through the one shared multiplier, the sum and the done state; a zero error goes from
// the integrator update straight to done. a new input is taken only back in idle, and
// the result register frees the input side while a result waits. reset clears the
// integrator, the gains and the window, and leaves the block idle with no result pending
// depends on pipc_pkg, pipc_if, pipc_csr, pipc_mul, pipc_seq
`timescale 1ns / 1ps

module pi_position_controller (
   input  logic        clock,
   input  logic        reset,
   pipc_req_if.sink    req_ch,
   pipc_rsp_if.source  rsp_ch,
   pipc_csr_if.sink    csr_ch
);

   localparam int PosW  = pipc_pkg::PosW;
   localparam int OpW   = pipc_pkg::OpW;
   localparam int ProdW = pipc_pkg::ProdW;

   pipc_pkg::gains_type gains;
   pipc_pkg::ctrl_type  ctrl;

   logic signed [PosW-1:0]  err_ff, err_in;
   logic signed [PosW-1:0]  integ_ff, integ_in;
   logic signed [ProdW-1:0] pterm_ff;
   logic signed [ProdW-1:0] prod, total;
   logic signed [pipc_pkg::DriveW-1:0] res_ff, res_in;
   logic                    brake_ff, brake_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [pipc_pkg::DriveW-1:0] drive_ff;
   logic                    braking_ff;
   logic signed [PosW:0]    err_wide, sum_wide, mag;
   logic signed [PosW:0]    integ_hi, integ_lo;
   logic signed [OpW-1:0]   mul_a;
   logic [pipc_pkg::GainW-1:0] mul_b;
   logic                    err_zero, out_free;

   pipc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .gains  (gains)
   );

   pipc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .err_zero  (err_zero),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   pipc_mul u_mul (
      .clock (clock),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .prod  (prod)
   );

   assign req_ch.ready = ctrl.req_ready;
   assign err_zero     = (err_ff == '0);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign err_in       = ctrl.capture ? PosW'(req_ch.target_pos - req_ch.actual_pos) : err_ff;

   // integrator update with window check and saturation
   assign err_wide = {err_ff[PosW-1], err_ff};
   assign mag      = err_ff[PosW-1] ? -err_wide : err_wide;
   assign sum_wide = {integ_ff[PosW-1], integ_ff} + err_wide;
   assign integ_hi = {pipc_pkg::IntegMax[PosW-1], pipc_pkg::IntegMax};
   assign integ_lo = {pipc_pkg::IntegMin[PosW-1], pipc_pkg::IntegMin};

   always_comb begin
      integ_in = integ_ff;
      brake_in = brake_ff;
      if (ctrl.integ_upd) begin
         brake_in = err_zero;
         if (!err_zero) begin
            if (mag <= $signed({1'b0, gains.integ_window})) begin
               if (sum_wide > integ_hi) begin
                  integ_in = pipc_pkg::IntegMax;
               end else if (sum_wide < integ_lo) begin
                  integ_in = pipc_pkg::IntegMin;
               end else begin
                  integ_in = sum_wide[PosW-1:0];
               end
            end else begin
               integ_in = '0;
            end
         end
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      case (ctrl.mul_op)
         pipc_pkg::MOP_ERR_FF: begin
            mul_a = {{(OpW-PosW){err_ff[PosW-1]}}, err_ff};
            mul_b = gains.feedforward_gain;
         end
         pipc_pkg::MOP_PROD_KP: begin
            mul_a = prod[OpW-1:0];
            mul_b = gains.prop_gain;
         end
         pipc_pkg::MOP_INT_FF: begin
            mul_a = {{(OpW-PosW){integ_ff[PosW-1]}}, integ_ff};
            mul_b = gains.feedforward_gain;
         end
         pipc_pkg::MOP_PROD_KI: begin
            mul_a = prod[OpW-1:0];
            mul_b = gains.integ_gain;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sum and clamp
   assign total = pterm_ff + prod;

   always_comb begin
      res_in = res_ff;
      if (ctrl.integ_upd && err_zero) begin
         res_in = '0;
      end else if (ctrl.save_sum) begin
         if (total > pipc_pkg::DriveMax) begin
            res_in = pipc_pkg::DriveMax[pipc_pkg::DriveW-1:0];
         end else if (total < pipc_pkg::DriveMin) begin
            res_in = pipc_pkg::DriveMin[pipc_pkg::DriveW-1:0];
         end else begin
            res_in = total[pipc_pkg::DriveW-1:0];
         end
      end
   end

   // result register on the output channel
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.drive_power = drive_ff;
   assign rsp_ch.braking     = braking_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      res_ff   <= res_in;
      brake_ff <= brake_in;
      if (ctrl.save_pterm) begin
         pterm_ff <= prod;
      end
      if (ctrl.load_out) begin
         drive_ff   <= res_ff;
         braking_ff <= brake_ff;
      end
   end

endmodule

// ===== hdl/pipc_csr.sv =====
// gain and window registers, written through the configuration channel
// depends on pipc_pkg and pipc_if
`timescale 1ns / 1ps

module pipc_csr (
   input  logic                clock,
   input  logic                reset,
   pipc_csr_if.sink            csr_ch,
   output pipc_pkg::gains_type gains
);

   pipc_pkg::gains_type gains_ff, gains_in;

   assign csr_ch.ready = 1'b1;
   assign gains = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            pipc_pkg::RegPropGain:  gains_in.prop_gain        = csr_ch.data;
            pipc_pkg::RegIntegGain: gains_in.integ_gain       = csr_ch.data;
            pipc_pkg::RegFfGain:    gains_in.feedforward_gain = csr_ch.data;
            pipc_pkg::RegIntegWin:  gains_in.integ_window     = csr_ch.data;
            default:                gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule

// ===== hdl/pipc_mul.sv =====
// shared signed by unsigned multiplier with registered product
// depends on pipc_pkg
`timescale 1ns / 1ps

module pipc_mul (
   input  logic                              clock,
   input  logic signed [pipc_pkg::OpW-1:0]   a_in,
   input  logic [pipc_pkg::GainW-1:0]        b_in,
   output logic signed [pipc_pkg::ProdW-1:0] prod
);

   logic signed [pipc_pkg::ProdW-1:0] a_ext, b_ext, prod_in, prod_ff;

   assign a_ext   = {{(pipc_pkg::ProdW-pipc_pkg::OpW){a_in[pipc_pkg::OpW-1]}}, a_in};
   assign b_ext   = {{(pipc_pkg::ProdW-pipc_pkg::GainW){1'b0}}, b_in};
   assign prod_in = a_ext * b_ext;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== hdl/pipc_seq.sv =====
// sequencer stepping one control tick through the shared multiplier
// depends on pipc_pkg
`timescale 1ns / 1ps

module pipc_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               err_zero,
   input  logic               out_free,
   output pipc_pkg::ctrl_type ctrl
);

   pipc_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pipc_pkg::ST_IDLE:   if (req_valid) state_in = pipc_pkg::ST_INTEG;
         pipc_pkg::ST_INTEG: begin
            state_in = err_zero ? pipc_pkg::ST_DONE : pipc_pkg::ST_MUL_P1;
         end
         pipc_pkg::ST_MUL_P1: state_in = pipc_pkg::ST_MUL_P2;
         pipc_pkg::ST_MUL_P2: state_in = pipc_pkg::ST_MUL_I1;
         pipc_pkg::ST_MUL_I1: state_in = pipc_pkg::ST_MUL_I2;
         pipc_pkg::ST_MUL_I2: state_in = pipc_pkg::ST_SUM;
         pipc_pkg::ST_SUM:    state_in = pipc_pkg::ST_DONE;
         pipc_pkg::ST_DONE:   if (out_free) state_in = pipc_pkg::ST_IDLE;
         default:             state_in = pipc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl        = '0;
      ctrl.mul_op = pipc_pkg::MOP_ERR_FF;
      case (state_ff)
         pipc_pkg::ST_IDLE: begin
            ctrl.req_ready = 1'b1;
            ctrl.capture   = req_valid;
         end
         pipc_pkg::ST_INTEG:  ctrl.integ_upd = 1'b1;
         pipc_pkg::ST_MUL_P1: ctrl.mul_op = pipc_pkg::MOP_ERR_FF;
         pipc_pkg::ST_MUL_P2: ctrl.mul_op = pipc_pkg::MOP_PROD_KP;
         pipc_pkg::ST_MUL_I1: begin
            ctrl.mul_op     = pipc_pkg::MOP_INT_FF;
            ctrl.save_pterm = 1'b1;
         end
         pipc_pkg::ST_MUL_I2: ctrl.mul_op = pipc_pkg::MOP_PROD_KI;
         pipc_pkg::ST_SUM:    ctrl.save_sum = 1'b1;
         pipc_pkg::ST_DONE:   ctrl.load_out = out_free;
         default:             ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pipc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== bench/pi_position_controller_test.sv =====
// testbench for pi_position_controller: directed and random control ticks under several gain
// settings, results checked against an in-bench pi predictor with integrator window and clamp
// depends on pipc_pkg, pipc_if and the pi_position_controller rtl
`timescale 1ns / 1ps

module pi_position_controller_test;

   typedef struct {
      logic signed [pipc_pkg::PosW-1:0] actual_pos;
      logic signed [pipc_pkg::PosW-1:0] target_pos;
   } tick_type;

   typedef struct {
      logic signed [pipc_pkg::DriveW-1:0] drive_power;
      logic                               braking;
   } drive_type;

   logic clock = 1'b0;
   logic reset;

   pipc_req_if req_ch();
   pipc_rsp_if rsp_ch();
   pipc_csr_if csr_ch();

   pi_position_controller i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   tick_type                         pending_ticks[$];
   drive_type                        expected_drives[$];
   pipc_pkg::gains_type              model_gains;
   logic signed [pipc_pkg::PosW-1:0] integ_acc;
   tick_type                         next_tick;
   drive_type                        want;
   int                               mismatches = 0;
   int                               results_seen = 0;
   int                               burst_left = 0;
   int                               gap_left = 0;
   int                               stall_pct = 0;
   int                               pattern_left = 0;
   int                               hold_left = 0;
   bit                               hold_done = 1'b0;
   bit                               next_valid;
   bit                               next_ready;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one control tick of the pi law, updates the integrator copy
   function automatic drive_type control_tick(input logic signed [pipc_pkg::PosW-1:0] act,
                                              input logic signed [pipc_pkg::PosW-1:0] tgt);
      drive_type                        r;
      logic signed [pipc_pkg::PosW-1:0] err;
      int                               mag;
      int                               acc;
      int                               integ_term;
      int                               prop_term;
      int                               total;
      err = tgt - act;
      if (err == 0) begin
         r.drive_power = '0;
         r.braking = 1'b1;
         return r;
      end
      mag = (err < 0) ? -int'(err) : int'(err);
      integ_term = 0;
      if (mag <= int'(model_gains.integ_window)) begin
         acc = int'(integ_acc) + int'(err);
         if (acc > int'(pipc_pkg::IntegMax)) acc = int'(pipc_pkg::IntegMax);
         else if (acc < int'(pipc_pkg::IntegMin)) acc = int'(pipc_pkg::IntegMin);
         integ_acc = pipc_pkg::PosW'(acc);
         integ_term = int'(integ_acc) * int'(model_gains.feedforward_gain)
                      * int'(model_gains.integ_gain);
      end else begin
         integ_acc = '0;
      end
      prop_term = int'(err) * int'(model_gains.feedforward_gain) * int'(model_gains.prop_gain);
      total = prop_term + integ_term;
      if (total > int'(pipc_pkg::DriveMax)) total = int'(pipc_pkg::DriveMax);
      else if (total < int'(pipc_pkg::DriveMin)) total = int'(pipc_pkg::DriveMin);
      r.drive_power = pipc_pkg::DriveW'(total);
      r.braking = 1'b0;
      return r;
   endfunction

   function automatic void flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t ns: %s", $time, msg);
   endfunction

   function automatic logic [pipc_pkg::GainW-1:0] pick_setting();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return pipc_pkg::GainW'($urandom_range(127, 128));
         3, 4, 5: return pipc_pkg::GainW'($urandom_range(1, 8));
         default: return pipc_pkg::GainW'($urandom);
      endcase
   endfunction

   task automatic queue_tick(input logic signed [pipc_pkg::PosW-1:0] act,
                             input logic signed [pipc_pkg::PosW-1:0] tgt);
      pending_ticks.push_back('{act, tgt});
   endtask

   task automatic wait_for_drain();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_ch.valid || expected_drives.size() != 0);
   endtask

   // leaves valid high, the caller lowers it after the last write
   task automatic csr_write(input logic [pipc_pkg::CsrIdxW-1:0] idx,
                            input logic [pipc_pkg::GainW-1:0] value);
      csr_ch.index <= idx;
      csr_ch.data <= value;
      csr_ch.valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ch.ready);
   endtask

   task automatic apply_gains(input logic [pipc_pkg::GainW-1:0] kp,
                              input logic [pipc_pkg::GainW-1:0] ki,
                              input logic [pipc_pkg::GainW-1:0] ff,
                              input logic [pipc_pkg::GainW-1:0] win,
                              input bit junk);
      wait_for_drain();
      @(posedge clock);
      csr_write(pipc_pkg::RegPropGain, kp);
      csr_write(pipc_pkg::RegIntegGain, ki);
      csr_write(pipc_pkg::RegFfGain, ff);
      csr_write(pipc_pkg::RegIntegWin, win);
      if (junk) begin
         // unmapped indexes must leave the gains alone
         csr_write('1, '1);
         csr_write(pipc_pkg::CsrIdxW'($urandom_range(int'(pipc_pkg::RegIntegWin) + 1,
                                                     (1 << pipc_pkg::CsrIdxW) - 1)),
                   pipc_pkg::GainW'($urandom));
      end
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // sender: bursts and gaps, prediction on each input transfer
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.actual_pos <= '0;
         req_ch.target_pos <= '0;
         model_gains = '0;
         integ_acc = '0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               pipc_pkg::RegPropGain:  model_gains.prop_gain = csr_ch.data;
               pipc_pkg::RegIntegGain: model_gains.integ_gain = csr_ch.data;
               pipc_pkg::RegFfGain:    model_gains.feedforward_gain = csr_ch.data;
               pipc_pkg::RegIntegWin:  model_gains.integ_window = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expected_drives.push_back(control_tick(req_ch.actual_pos, req_ch.target_pos));
         if (!req_ch.valid || req_ch.ready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_ticks.size() != 0) begin
               next_tick = pending_ticks.pop_front();
               req_ch.actual_pos <= next_tick.actual_pos;
               req_ch.target_pos <= next_tick.target_pos;
               next_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            req_ch.valid <= next_valid;
         end
      end
   end

   // receiver: checks each result transfer, stalls on its own pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_drives.size() == 0) begin
               flag_mismatch($sformatf("unexpected result drive_power=%0d braking=%0b",
                                       rsp_ch.drive_power, rsp_ch.braking));
            end else begin
               want = expected_drives.pop_front();
               if (rsp_ch.drive_power !== want.drive_power)
                  flag_mismatch($sformatf("drive_power expected %0d got %0d",
                                          want.drive_power, rsp_ch.drive_power));
               if (rsp_ch.braking !== want.braking)
                  flag_mismatch($sformatf("braking expected %0b got %0b",
                                          want.braking, rsp_ch.braking));
            end
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(20, 80);
            case ($urandom_range(0, 4))
               0, 1: stall_pct = 0;
               2: stall_pct = 25;
               3: stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end else begin
            pattern_left--;
         end
         // one long hold-off so the block backs up into its input
         if (!hold_done && results_seen >= 300) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            next_ready = ($urandom_range(0, 99) >= stall_pct);
         end
         rsp_ch.ready <= next_ready;
      end
   end

   initial begin
      int                               n;
      int                               ph;
      logic signed [pipc_pkg::PosW-1:0] a;
      logic signed [pipc_pkg::PosW-1:0] t;
      reset = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // gains at reset values
      queue_tick(0, 0);
      queue_tick(127, -128);
      queue_tick(-128, 127);
      queue_tick(-128, -128);

      // full gains: integrator saturation both ways, drive clamp, braking
      apply_gains('1, '1, '1, '1, 1'b0);
      queue_tick(0, 127);
      queue_tick(0, 127);
      queue_tick(0, 127);
      queue_tick(0, -128);
      queue_tick(-128, 0);
      queue_tick(-128, 0);
      queue_tick(5, 5);
      queue_tick(127, 127);

      // most negative error just outside the window
      apply_gains(1, 1, 1, 127, 1'b1);
      queue_tick(0, -128);
      queue_tick(0, 1);
      queue_tick(1, 0);

      // window of 128 admits the most negative error
      apply_gains(3, 2, 1, 128, 1'b0);
      queue_tick(0, -128);
      queue_tick(-1, 127);
      queue_tick(0, 0);

      // zero window clears the integrator on every nonzero error
      apply_gains('1, '0, '1, '0, 1'b0);
      queue_tick(0, 1);
      queue_tick(0, -1);

      for (ph = 0; ph < 5; ph++) begin
         apply_gains(pick_setting(), pick_setting(), pick_setting(), pick_setting(),
                     $urandom_range(0, 1));
         for (n = 0; n < 190; n++) begin
            a = pipc_pkg::PosW'($urandom);
            case ($urandom_range(0, 9))
               0, 1: t = a;
               2, 3, 4, 5, 6: t = a + pipc_pkg::PosW'($urandom_range(0, 16) - 8);
               default: t = pipc_pkg::PosW'($urandom);
            endcase
            queue_tick(a, t);
         end
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_drives.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
